// ----- design/rsce_pkg.sv -----
// Package with the sequencer states, field widths and limits of the route swap cost evaluator.
`timescale 1ns / 1ps

package rsce_pkg;

    localparam int CITY_BITS   = 6;
    localparam int CITY_SPAN   = 64;
    localparam int WEIGHT_BITS = 24;
    localparam int EDGE_BITS   = WEIGHT_BITS + 1;
    localparam int LEN_BITS    = 30;
    localparam int SUM_BITS    = 35;
    localparam int PAIR_BITS   = 11;
    localparam int DIV_STEPS   = SUM_BITS;

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Operation codes carried in the input tuser.
    localparam logic [2:0] ACT_LOAD_EDGE = 3'd0;
    localparam logic [2:0] ACT_LOAD_POS  = 3'd1;
    localparam logic [2:0] ACT_MEASURE   = 3'd2;
    localparam logic [2:0] ACT_EVAL_SWAP = 3'd3;
    localparam logic [2:0] ACT_COMMIT    = 3'd4;

    // Status codes carried in the output tuser.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_NO_LINKS = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EDGE_W1,
        ST_EDGE_W2,
        ST_POS_W,
        ST_M_RDA,
        ST_M_CAPA,
        ST_M_RDB,
        ST_M_EDGE,
        ST_M_ACC,
        ST_M_END,
        ST_DIV,
        ST_S_SEL,
        ST_S_CAPA,
        ST_S_EDGE,
        ST_S_ACC,
        ST_S_FIN,
        ST_C_RDI,
        ST_C_RDJ,
        ST_C_WI,
        ST_C_WJ,
        ST_DONE
    } state_t;

endpackage

// ----- design/route_swap_cost_evaluator_core.sv -----
// Top level of the route swap cost evaluator: tour and edge memories, sequencer and datapath.
//
// Channel   Direction  Contents
// s_axis    in         tdata: city_a, city_b, edge_weight, edge_linked, position_i, position_j
//                      tuser: action
// m_axis    out        tdata: tour_length, unlinked_count, max_edge, average_edge, linked_pairs
//                      tuser: status
// cfg       in         cfg_we / cfg_wdata: route_length
//
// An edge load writes both table entries, a position load one tour entry. An evaluate swap reads
// up to eight candidate edges through one shared edge-table read port and one tour read port; a
// commit then exchanges the two tour entries. A measure visits every city pair, reading the first
// city of each row once, then runs the bit-serial divider for the average.
// Reset clears control state and the length, count, maximum and average registers; the
// memories hold nothing valid until written. s_tready is high only in the idle state; a
// result waiting on a stalled m_tready holds there while the next transaction is taken.
`timescale 1ns / 1ps

module route_swap_cost_evaluator_core
    import rsce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] city_a, [11:6] city_b, [35:12] edge_weight, [36] edge_linked,
    // [42:37] position_i, [48:43] position_j, [55:49] zero
    input  logic [55:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [29:0] tour_length, [35:30] unlinked_count, [59:36] max_edge,
    // [83:60] average_edge, [94:84] linked_pairs, [95] zero
    output logic [95:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser
);

    state_t state_reg, state_next;

    // Memories.
    logic [CITY_BITS-1:0] tour_mem [CITY_SPAN];
    logic [EDGE_BITS-1:0] edge_mem [CITY_SPAN*CITY_SPAN];
    logic                 tour_we, edge_we;
    logic [CITY_BITS-1:0] tour_waddr, tour_wdata, tour_raddr, tour_rdata;
    logic [2*CITY_BITS-1:0] edge_waddr, edge_raddr;
    logic [EDGE_BITS-1:0] edge_wdata, edge_rdata;

    // Configuration and architectural registers.
    logic [6:0]             route_length_reg;
    logic [LEN_BITS-1:0]    length_reg;
    logic [5:0]             unlinked_reg;
    logic [WEIGHT_BITS-1:0] max_reg, average_reg;

    // Latched input fields.
    logic [2:0]             act_reg;
    logic [CITY_BITS-1:0]   ca_reg, cb_reg, pi_reg, pj_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic                   lk_reg;

    // Working registers.
    logic [CITY_BITS-1:0]   ta_reg;
    logic [6:0]             a_reg, b_reg;
    logic [2:0]             idx_reg;
    logic [LEN_BITS-1:0]    acc_len_reg;
    logic [6:0]             acc_cons_reg;
    logic [SUM_BITS-1:0]    acc_sum_reg;
    logic [WEIGHT_BITS-1:0] acc_max_reg;
    logic [PAIR_BITS-1:0]   acc_pairs_reg;
    logic [WEIGHT_BITS+1:0] wb_reg, wa_reg;
    logic [2:0]             lb_reg, la_reg;
    logic [SUM_BITS-1:0]    div_q_reg;
    logic [PAIR_BITS-1:0]   div_r_reg;
    logic [5:0]             div_cnt_reg;

    // Result registers.
    logic [LEN_BITS-1:0]    res_len_reg;
    logic [5:0]             res_unl_reg;
    logic [PAIR_BITS-1:0]   res_pairs_reg;
    logic [1:0]             res_stat_reg;
    logic                   m_valid_reg;
    logic [95:0]            m_data_reg;
    logic [1:0]             m_user_reg;

    // Input unpacking.
    logic [CITY_BITS-1:0]   in_ca, in_cb, in_pi, in_pj;
    logic [WEIGHT_BITS-1:0] in_w;
    logic                   in_lk, accept;

    assign in_ca  = s_tdata[5:0];
    assign in_cb  = s_tdata[11:6];
    assign in_w   = s_tdata[35:12];
    assign in_lk  = s_tdata[36];
    assign in_pi  = s_tdata[42:37];
    assign in_pj  = s_tdata[48:43];
    assign accept = s_tvalid && s_tready;

    // Effective city count and range checks.
    logic [6:0] n_eff;
    logic       in_range;
    assign n_eff    = (route_length_reg > 7'(CITY_SPAN)) ? 7'(CITY_SPAN) : route_length_reg;
    assign in_range = ({1'b0, in_pi} < n_eff) && ({1'b0, in_pj} < n_eff);

    // Swap candidate edge selection: starts at i-1, i, j-1, j.
    logic signed [7:0]    cand [4];
    logic signed [7:0]    cand_k;
    logic                 cand_ok, cand_dup;
    logic [CITY_BITS-1:0] pos_k, pos_k1, map_k, map_k1;

    always_comb
    begin
        cand[0] = $signed({2'b00, pi_reg}) - 8'sd1;
        cand[1] = $signed({2'b00, pi_reg});
        cand[2] = $signed({2'b00, pj_reg}) - 8'sd1;
        cand[3] = $signed({2'b00, pj_reg});
        cand_k  = cand[idx_reg[1:0]];
        cand_dup = 1'b0;
        for (int d = 0; d < 3; d++)
        begin
            if ((2'(d) < idx_reg[1:0]) && (cand[d] == cand_k))
            begin
                cand_dup = 1'b1;
            end
        end
        cand_ok = (cand_k >= 8'sd0) && ((cand_k + 8'sd1) < $signed({1'b0, n_eff}))
                  && !cand_dup;
        pos_k  = cand_k[5:0];
        pos_k1 = 6'(cand_k[5:0] + 6'd1);
        map_k  = pos_k;
        map_k1 = pos_k1;
        // The second pass sees the tour with the two positions exchanged.
        if (idx_reg[2])
        begin
            if (pos_k == pi_reg)       map_k = pj_reg;
            else if (pos_k == pj_reg)  map_k = pi_reg;
            if (pos_k1 == pi_reg)      map_k1 = pj_reg;
            else if (pos_k1 == pj_reg) map_k1 = pi_reg;
        end
    end

    // Divider step: one quotient bit per cycle.
    logic [PAIR_BITS:0] div_trial;
    logic               div_bit;
    assign div_trial = {div_r_reg, div_q_reg[SUM_BITS-1]};
    assign div_bit   = div_trial >= {1'b0, acc_pairs_reg};

    // Swap outcome with saturation.
    logic signed [32:0] nl_full;
    logic signed [8:0]  nu_full;
    logic [LEN_BITS-1:0] nl_sat;
    logic [5:0]          nu_sat;

    always_comb
    begin
        nl_full = $signed({3'b000, length_reg}) - $signed({7'd0, wb_reg})
                  + $signed({7'd0, wa_reg});
        nu_full = $signed({3'b000, unlinked_reg}) + $signed({6'd0, lb_reg})
                  - $signed({6'd0, la_reg});
        if (nl_full < 33'sd0)
            nl_sat = '0;
        else if (nl_full > $signed({3'b000, LEN_MAX}))
            nl_sat = LEN_MAX;
        else
            nl_sat = nl_full[LEN_BITS-1:0];
        if (nu_full < 9'sd0)
            nu_sat = '0;
        else if (nu_full > 9'sd63)
            nu_sat = 6'd63;
        else
            nu_sat = nu_full[5:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        ACT_LOAD_EDGE: state_next = ST_EDGE_W1;
                        ACT_LOAD_POS:  state_next = ST_POS_W;
                        ACT_MEASURE:   state_next = (n_eff < 7'd2) ? ST_M_END : ST_M_RDA;
                        ACT_EVAL_SWAP,
                        ACT_COMMIT:    state_next = (n_eff >= 7'd2 && in_range) ?
                                                    ST_S_SEL : ST_DONE;
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_EDGE_W1: state_next = ST_EDGE_W2;
            ST_EDGE_W2: state_next = ST_DONE;
            ST_POS_W:   state_next = ST_DONE;
            ST_M_RDA:   state_next = ST_M_CAPA;
            ST_M_CAPA:  state_next = ST_M_EDGE;
            ST_M_RDB:   state_next = ST_M_EDGE;
            ST_M_EDGE:  state_next = ST_M_ACC;
            ST_M_ACC:
            begin
                if (b_reg + 7'd1 < n_eff)
                    state_next = ST_M_RDB;
                else if (a_reg + 7'd2 < n_eff)
                    state_next = ST_M_RDA;
                else
                    state_next = ST_M_END;
            end
            ST_M_END:   state_next = (acc_pairs_reg == '0) ? ST_DONE : ST_DIV;
            ST_DIV:     state_next = (div_cnt_reg == 6'(DIV_STEPS - 1)) ? ST_DONE : ST_DIV;
            ST_S_SEL:
            begin
                if (cand_ok)
                    state_next = ST_S_CAPA;
                else if (idx_reg == 3'd7)
                    state_next = ST_S_FIN;
            end
            ST_S_CAPA:  state_next = ST_S_EDGE;
            ST_S_EDGE:  state_next = ST_S_ACC;
            ST_S_ACC:   state_next = (idx_reg == 3'd7) ? ST_S_FIN : ST_S_SEL;
            ST_S_FIN:   state_next = (act_reg == ACT_COMMIT) ? ST_C_RDI : ST_DONE;
            ST_C_RDI:   state_next = ST_C_RDJ;
            ST_C_RDJ:   state_next = ST_C_WI;
            ST_C_WI:    state_next = ST_C_WJ;
            ST_C_WJ:    state_next = ST_DONE;
            ST_DONE:    state_next = (!m_valid_reg || m_tready) ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory port controls per state.
    always_comb
    begin
        tour_we    = 1'b0;
        tour_waddr = pi_reg;
        tour_wdata = ca_reg;
        tour_raddr = a_reg[5:0];
        edge_we    = 1'b0;
        edge_waddr = {ca_reg, cb_reg};
        edge_wdata = {lk_reg, w_reg};
        edge_raddr = {ta_reg, tour_rdata};
        case (state_reg)
            ST_EDGE_W1: edge_we = 1'b1;
            ST_EDGE_W2:
            begin
                edge_we    = 1'b1;
                edge_waddr = {cb_reg, ca_reg};
            end
            ST_POS_W:   tour_we = 1'b1;
            ST_M_RDA:   tour_raddr = a_reg[5:0];
            ST_M_CAPA,
            ST_M_RDB:   tour_raddr = b_reg[5:0];
            ST_S_SEL:   tour_raddr = map_k;
            ST_S_CAPA:  tour_raddr = map_k1;
            ST_C_RDI:   tour_raddr = pi_reg;
            ST_C_RDJ:   tour_raddr = pj_reg;
            ST_C_WI:
            begin
                tour_we    = 1'b1;
                tour_wdata = tour_rdata;
            end
            ST_C_WJ:
            begin
                tour_we    = 1'b1;
                tour_waddr = pj_reg;
                tour_wdata = ta_reg;
            end
            default:    tour_we = 1'b0;
        endcase
    end

    // Tour memory.
    always_ff @(posedge clk)
    begin
        if (tour_we)
        begin
            tour_mem[tour_waddr] <= tour_wdata;
        end
        tour_rdata <= tour_mem[tour_raddr];
    end

    // Edge table memory.
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rdata <= edge_mem[edge_raddr];
    end

    // Control state, configuration and architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            route_length_reg <= '0;
            length_reg       <= '0;
            unlinked_reg     <= '0;
            max_reg          <= '0;
            average_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                route_length_reg <= cfg_wdata;
            end
            if (state_reg == ST_M_END)
            begin
                length_reg   <= acc_len_reg;
                unlinked_reg <= (n_eff == '0) ? 6'd0 : 6'(n_eff - 7'd1 - acc_cons_reg);
                max_reg      <= acc_max_reg;
                if (acc_pairs_reg == '0)
                begin
                    average_reg <= '0;
                end
            end
            if (state_reg == ST_DIV && div_cnt_reg == 6'(DIV_STEPS - 1))
            begin
                average_reg <= div_q_reg[WEIGHT_BITS-2:0] == '0 && 1'b0 ? '0 :
                               {div_q_reg[WEIGHT_BITS-2:0], div_bit};
            end
            if (state_reg == ST_S_FIN && act_reg == ACT_COMMIT)
            begin
                length_reg   <= nl_sat;
                unlinked_reg <= nu_sat;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_reg       <= s_tuser;
                    ca_reg        <= in_ca;
                    cb_reg        <= in_cb;
                    w_reg         <= in_w;
                    lk_reg        <= in_lk;
                    pi_reg        <= in_pi;
                    pj_reg        <= in_pj;
                    a_reg         <= 7'd0;
                    b_reg         <= 7'd1;
                    idx_reg       <= 3'd0;
                    acc_len_reg   <= '0;
                    acc_cons_reg  <= '0;
                    acc_sum_reg   <= '0;
                    acc_max_reg   <= '0;
                    acc_pairs_reg <= '0;
                    wb_reg        <= '0;
                    wa_reg        <= '0;
                    lb_reg        <= '0;
                    la_reg        <= '0;
                    res_len_reg   <= length_reg;
                    res_unl_reg   <= unlinked_reg;
                    res_pairs_reg <= '0;
                    res_stat_reg  <= STAT_OK;
                    if ((s_tuser == ACT_EVAL_SWAP || s_tuser == ACT_COMMIT)
                        && n_eff >= 7'd2 && !in_range)
                    begin
                        res_stat_reg <= STAT_RANGE;
                    end
                end
            end
            ST_M_CAPA:
            begin
                ta_reg <= tour_rdata;
            end
            ST_M_ACC:
            begin
                // Every linked tour pair counts toward the mean; linked neighbors also toward the length.
                if (edge_rdata[EDGE_BITS-1])
                begin
                    acc_sum_reg   <= acc_sum_reg + SUM_BITS'(edge_rdata[WEIGHT_BITS-1:0]);
                    acc_pairs_reg <= acc_pairs_reg + PAIR_BITS'(1);
                    if (edge_rdata[WEIGHT_BITS-1:0] > acc_max_reg)
                    begin
                        acc_max_reg <= edge_rdata[WEIGHT_BITS-1:0];
                    end
                    if (b_reg == a_reg + 7'd1)
                    begin
                        acc_len_reg  <= acc_len_reg + LEN_BITS'(edge_rdata[WEIGHT_BITS-1:0]);
                        acc_cons_reg <= acc_cons_reg + 7'd1;
                    end
                end
                if (b_reg + 7'd1 < n_eff)
                begin
                    b_reg <= b_reg + 7'd1;
                end
                else
                begin
                    a_reg <= a_reg + 7'd1;
                    b_reg <= a_reg + 7'd2;
                end
            end
            ST_M_END:
            begin
                res_len_reg   <= acc_len_reg;
                res_unl_reg   <= (n_eff == '0) ? 6'd0 : 6'(n_eff - 7'd1 - acc_cons_reg);
                res_pairs_reg <= acc_pairs_reg;
                res_stat_reg  <= (acc_pairs_reg == '0) ? STAT_NO_LINKS : STAT_OK;
                div_q_reg     <= acc_sum_reg;
                div_r_reg     <= '0;
                div_cnt_reg   <= '0;
            end
            ST_DIV:
            begin
                div_r_reg   <= div_bit ? PAIR_BITS'(div_trial - {1'b0, acc_pairs_reg}) :
                                         div_trial[PAIR_BITS-1:0];
                div_q_reg   <= {div_q_reg[SUM_BITS-2:0], div_bit};
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
            ST_S_SEL:
            begin
                if (!cand_ok && idx_reg != 3'd7)
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
            ST_S_CAPA:
            begin
                ta_reg <= tour_rdata;
            end
            ST_S_ACC:
            begin
                if (edge_rdata[EDGE_BITS-1])
                begin
                    if (idx_reg[2])
                    begin
                        wa_reg <= wa_reg + (WEIGHT_BITS+2)'(edge_rdata[WEIGHT_BITS-1:0]);
                        la_reg <= la_reg + 3'd1;
                    end
                    else
                    begin
                        wb_reg <= wb_reg + (WEIGHT_BITS+2)'(edge_rdata[WEIGHT_BITS-1:0]);
                        lb_reg <= lb_reg + 3'd1;
                    end
                end
                idx_reg <= idx_reg + 3'd1;
            end
            ST_S_FIN:
            begin
                res_len_reg <= nl_sat;
                res_unl_reg <= nu_sat;
            end
            ST_C_RDJ:
            begin
                ta_reg <= tour_rdata;
            end
            default:
            begin
                ta_reg <= ta_reg;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
        begin
            m_data_reg <= {1'b0, res_pairs_reg, average_reg, max_reg, res_unl_reg, res_len_reg};
            m_user_reg <= res_stat_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
